// File: rtl/sorted_station_table_core_macros.svh
// Assertion helpers for the station table sequencer RTL (sst_seq).
// Each macro expects signals named clk and rst_n in the using module.
`ifndef SORTED_STATION_TABLE_CORE_MACROS_SVH
`define SORTED_STATION_TABLE_CORE_MACROS_SVH

// The expression holds at every clock edge out of reset.
`define SST_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// The consequent holds in the same cycle as the antecedent.
`define SST_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define SST_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/sst_pkg.sv
`default_nettype none

package sst_pkg;

  // Field widths of the channels.
  localparam int OP_W      = 3;
  localparam int FREQ_W    = 16;
  localparam int SLOT_W    = 6;
  localparam int LABEL_W   = 64;
  localparam int FIDX_W    = 6;
  localparam int CNT_OUT_W = 7;
  localparam int ST_W      = 2;

  // Default number of table entries.
  localparam int DEF_TABLE_DEPTH = 64;

  // Frequencies reserved as terminators; never stored.
  localparam logic [FREQ_W-1:0] FREQ_RSV_LO = 16'h0000;
  localparam logic [FREQ_W-1:0] FREQ_RSV_HI = 16'hFFFF;

  // Command codes.
  typedef enum logic [OP_W-1:0] {
    OP_SEEK_UP = 3'd0,
    OP_SEEK_DN = 3'd1,
    OP_STORE   = 3'd2,
    OP_REMOVE  = 3'd3,
    OP_TOGGLE  = 3'd4,
    OP_LOOKUP  = 3'd5,
    OP_ZAP     = 3'd6,
    OP_NONE    = 3'd7
  } op_t;

  // Result status codes.
  typedef enum logic [ST_W-1:0] {
    ST_DONE = 2'd0,
    ST_MISS = 2'd1,
    ST_DROP = 2'd2,
    ST_BAD  = 2'd3
  } st_t;

  // One table entry as held in the memory.
  typedef struct packed {
    logic [FREQ_W-1:0]  freq;
    logic [LABEL_W-1:0] label;
  } entry_t;

  // One result beat.
  typedef struct packed {
    logic                 tune_valid;
    logic [FREQ_W-1:0]    tune_freq;
    logic                 found;
    logic [FIDX_W-1:0]    found_index;
    logic [LABEL_W-1:0]   label_out;
    logic [CNT_OUT_W-1:0] entry_count;
    st_t                  status;
  } res_t;

endpackage

`default_nettype wire

// File: rtl/sst_channels.sv
`default_nettype none

// Command channel.
interface sst_in_if;
  import sst_pkg::*;

  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     op;
  logic [FREQ_W-1:0]   freq;
  logic [SLOT_W-1:0]   slot;
  logic [LABEL_W-1:0]  label;

  modport source (output valid, output op, output freq, output slot, output label,
                  input ready);
  modport sink (input valid, input op, input freq, input slot, input label,
                output ready);
endinterface

// Result channel.
interface sst_out_if;
  import sst_pkg::*;

  logic                 valid;
  logic                 ready;
  logic                 tune_valid;
  logic [FREQ_W-1:0]    tune_freq;
  logic                 found;
  logic [FIDX_W-1:0]    found_index;
  logic [LABEL_W-1:0]   label_out;
  logic [CNT_OUT_W-1:0] entry_count;
  logic [ST_W-1:0]      status;

  modport source (output valid, output tune_valid, output tune_freq, output found,
                  output found_index, output label_out, output entry_count,
                  output status, input ready);
  modport sink (input valid, input tune_valid, input tune_freq, input found,
                input found_index, input label_out, input entry_count,
                input status, output ready);
endinterface

`default_nettype wire

// File: rtl/sst_ram.sv
`default_nettype none

module sst_ram #(
  parameter int DEPTH = sst_pkg::DEF_TABLE_DEPTH,
  parameter int WIDTH = $bits(sst_pkg::entry_t)
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port: registered read data, updated when re is set.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// File: rtl/sst_seq.sv
`default_nettype none

module sst_seq #(
  parameter int TABLE_DEPTH = sst_pkg::DEF_TABLE_DEPTH
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // Command side.
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [sst_pkg::OP_W-1:0]       in_op,
  input  logic [sst_pkg::FREQ_W-1:0]     in_freq,
  input  logic [sst_pkg::SLOT_W-1:0]     in_slot,
  input  logic [sst_pkg::LABEL_W-1:0]    in_label,
  // Result side.
  output logic                           res_valid,
  input  logic                           res_ready,
  output sst_pkg::res_t                  res,
  // Table memory.
  output logic                           ram_we,
  output logic [$clog2(TABLE_DEPTH)-1:0] ram_waddr,
  output sst_pkg::entry_t                ram_wdata,
  output logic                           ram_re,
  output logic [$clog2(TABLE_DEPTH)-1:0] ram_raddr,
  input  sst_pkg::entry_t                ram_rdata
);

  import sst_pkg::*;

  `include "sorted_station_table_core_macros.svh"

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int CMP_W = (CNT_W > SLOT_W) ? CNT_W : SLOT_W;
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(TABLE_DEPTH);
  localparam logic [CNT_W-1:0] ONE_C   = CNT_W'(1);

  typedef enum logic [3:0] {
    S_IDLE,
    S_SC_RD,
    S_SC_EV,
    S_DECIDE,
    S_INS_RD,
    S_INS_WR,
    S_WR_POS,
    S_RM_RD,
    S_RM_WR,
    S_Z_RD,
    S_Z_EV,
    S_FIN
  } state_t;

  state_t               state_r, state_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;
  op_t                  op_r, op_nxt;
  logic [FREQ_W-1:0]    freq_r, freq_nxt;
  logic [SLOT_W-1:0]    slot_r, slot_nxt;
  logic [LABEL_W-1:0]   label_r, label_nxt;
  logic [CNT_W-1:0]     idx_r, idx_nxt;
  logic [CNT_W-1:0]     dst_r, dst_nxt;
  logic                 hit_r, hit_nxt;
  logic [FREQ_W-1:0]    hit_freq_r, hit_freq_nxt;
  logic [LABEL_W-1:0]   hit_label_r, hit_label_nxt;
  logic [FREQ_W-1:0]    prev_freq_r, prev_freq_nxt;
  logic                 full_r, full_nxt;
  res_t                 res_r, res_nxt;

  logic                 in_rsv;
  logic                 eq;
  logic                 stop;
  op_t                  in_op_c;

  assign in_op_c   = op_t'(in_op);
  assign in_rsv    = (in_freq == FREQ_RSV_LO) || (in_freq == FREQ_RSV_HI);
  assign eq        = hit_r && (hit_freq_r == freq_r);
  assign stop      = (op_r == OP_SEEK_UP) ? (ram_rdata.freq > freq_r)
                                          : (ram_rdata.freq >= freq_r);
  assign in_ready  = (state_r == S_IDLE);
  assign res_valid = (state_r == S_FIN);

  // The count is reported as it stands once the command has finished.
  always_comb begin
    res             = res_r;
    res.entry_count = CNT_OUT_W'(count_r);
  end

  // Sequencer: scan the table in order, then shift or write entries; zap reads one entry by index.
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    op_nxt        = op_r;
    freq_nxt      = freq_r;
    slot_nxt      = slot_r;
    label_nxt     = label_r;
    idx_nxt       = idx_r;
    dst_nxt       = dst_r;
    hit_nxt       = hit_r;
    hit_freq_nxt  = hit_freq_r;
    hit_label_nxt = hit_label_r;
    prev_freq_nxt = prev_freq_r;
    full_nxt      = full_r;
    res_nxt       = res_r;
    ram_we        = 1'b0;
    ram_waddr     = dst_r[IDX_W-1:0];
    ram_wdata     = ram_rdata;
    ram_re        = 1'b0;
    ram_raddr     = idx_r[IDX_W-1:0];

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt    = in_op_c;
          freq_nxt  = in_freq;
          slot_nxt  = in_slot;
          label_nxt = in_label;
          idx_nxt   = '0;
          hit_nxt   = 1'b0;
          full_nxt  = 1'b0;
          res_nxt   = '0;
          unique case (in_op_c) inside
            OP_ZAP: begin
              if (CMP_W'(in_slot) < CMP_W'(count_r)) begin
                state_nxt = S_Z_RD;
              end else begin
                res_nxt.status = ST_MISS;
                state_nxt      = S_FIN;
              end
            end
            OP_NONE: begin
              state_nxt = S_FIN;
            end
            OP_STORE, OP_REMOVE, OP_TOGGLE, OP_LOOKUP: begin
              if (in_rsv) begin
                res_nxt.status = ST_BAD;
                state_nxt      = S_FIN;
              end else begin
                state_nxt = (count_r == '0) ? S_DECIDE : S_SC_RD;
              end
            end
            OP_SEEK_UP, OP_SEEK_DN: begin
              state_nxt = (count_r == '0) ? S_DECIDE : S_SC_RD;
            end
          endcase
        end
      end

      S_SC_RD: begin
        ram_re    = 1'b1;
        ram_raddr = idx_r[IDX_W-1:0];
        state_nxt = S_SC_EV;
      end

      // Stop at the first entry at or above the target (above it for seek up).
      S_SC_EV: begin
        if (stop) begin
          hit_nxt       = 1'b1;
          hit_freq_nxt  = ram_rdata.freq;
          hit_label_nxt = ram_rdata.label;
          state_nxt     = S_DECIDE;
        end else begin
          prev_freq_nxt = ram_rdata.freq;
          idx_nxt       = idx_r + ONE_C;
          state_nxt     = ((idx_r + ONE_C) == count_r) ? S_DECIDE : S_SC_RD;
        end
      end

      S_DECIDE: begin
        full_nxt  = (count_r == DEPTH_C);
        state_nxt = S_FIN;
        unique case (op_r) inside
          OP_SEEK_UP: begin
            if (hit_r) begin
              res_nxt.tune_valid = 1'b1;
              res_nxt.tune_freq  = hit_freq_r;
            end else begin
              res_nxt.status = ST_MISS;
            end
          end
          OP_SEEK_DN: begin
            if (idx_r != '0) begin
              res_nxt.tune_valid = 1'b1;
              res_nxt.tune_freq  = prev_freq_r;
            end else begin
              res_nxt.status = ST_MISS;
            end
          end
          OP_LOOKUP: begin
            if (eq) begin
              res_nxt.found       = 1'b1;
              res_nxt.found_index = FIDX_W'(idx_r);
              res_nxt.label_out   = hit_label_r;
            end else begin
              res_nxt.status = ST_MISS;
            end
          end
          OP_STORE, OP_REMOVE, OP_TOGGLE: begin
            if (eq && (op_r != OP_STORE)) begin
              // Remove: pull the following entries down by one.
              dst_nxt = idx_r;
              if ((idx_r + ONE_C) < count_r) begin
                state_nxt = S_RM_RD;
              end else begin
                count_nxt = count_r - ONE_C;
              end
            end else if (op_r == OP_REMOVE) begin
              res_nxt.status = ST_MISS;
            end else if (eq) begin
              // Same frequency already stored: replace the payload.
              state_nxt = S_WR_POS;
            end else if (idx_r == DEPTH_C) begin
              // Full table and the new entry is the highest: it falls off.
              res_nxt.status = ST_DROP;
            end else begin
              // Insert: push entries up, dropping the top one when full.
              dst_nxt   = (count_r == DEPTH_C) ? (DEPTH_C - ONE_C) : count_r;
              state_nxt = (dst_nxt > idx_r) ? S_INS_RD : S_WR_POS;
            end
          end
          OP_ZAP, OP_NONE: begin
            state_nxt = S_FIN;
          end
        endcase
      end

      S_INS_RD: begin
        ram_re    = 1'b1;
        ram_raddr = IDX_W'(dst_r - ONE_C);
        state_nxt = S_INS_WR;
      end

      S_INS_WR: begin
        ram_we    = 1'b1;
        ram_waddr = dst_r[IDX_W-1:0];
        ram_wdata = ram_rdata;
        dst_nxt   = dst_r - ONE_C;
        state_nxt = ((dst_r - ONE_C) > idx_r) ? S_INS_RD : S_WR_POS;
      end

      S_WR_POS: begin
        ram_we          = 1'b1;
        ram_waddr       = idx_r[IDX_W-1:0];
        ram_wdata.freq  = freq_r;
        ram_wdata.label = label_r;
        if (eq) begin
          res_nxt.status = ST_DONE;
        end else if (full_r) begin
          res_nxt.status = ST_DROP;
        end else begin
          count_nxt = count_r + ONE_C;
        end
        state_nxt = S_FIN;
      end

      S_RM_RD: begin
        ram_re    = 1'b1;
        ram_raddr = IDX_W'(dst_r + ONE_C);
        state_nxt = S_RM_WR;
      end

      S_RM_WR: begin
        ram_we    = 1'b1;
        ram_waddr = dst_r[IDX_W-1:0];
        ram_wdata = ram_rdata;
        dst_nxt   = dst_r + ONE_C;
        if ((dst_r + ONE_C + ONE_C) < count_r) begin
          state_nxt = S_RM_RD;
        end else begin
          count_nxt = count_r - ONE_C;
          state_nxt = S_FIN;
        end
      end

      S_Z_RD: begin
        ram_re    = 1'b1;
        ram_raddr = IDX_W'(slot_r);
        state_nxt = S_Z_EV;
      end

      S_Z_EV: begin
        res_nxt.tune_valid  = 1'b1;
        res_nxt.tune_freq   = ram_rdata.freq;
        res_nxt.found       = 1'b1;
        res_nxt.found_index = slot_r;
        res_nxt.label_out   = ram_rdata.label;
        state_nxt           = S_FIN;
      end

      S_FIN: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State and entry count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  // Command and scan registers.
  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    freq_r      <= freq_nxt;
    slot_r      <= slot_nxt;
    label_r     <= label_nxt;
    idx_r       <= idx_nxt;
    dst_r       <= dst_nxt;
    hit_r       <= hit_nxt;
    hit_freq_r  <= hit_freq_nxt;
    hit_label_r <= hit_label_nxt;
    prev_freq_r <= prev_freq_nxt;
    full_r      <= full_nxt;
    res_r       <= res_nxt;
  end

  // Checks on the sequencer.
  `SST_ASSERT_ALWAYS(a_count_bound, count_r <= DEPTH_C, "entry count above table depth")
  `SST_ASSERT_ALWAYS(a_port_excl, !(ram_we && ram_re), "memory read and write in one cycle")
  `SST_ASSERT_IMPL(a_we_state, ram_we, (state_r == S_INS_WR) || (state_r == S_RM_WR) || (state_r == S_WR_POS), "memory write outside a write state")
  `SST_ASSERT_IMPL(a_ins_order, state_r == S_INS_WR, dst_r > idx_r, "insert shift past the insert point")
  `SST_ASSERT_NEXT(a_idle_count, state_r == S_IDLE, $stable(count_r), "entry count moved while idle")

endmodule

`default_nettype wire

// File: rtl/sorted_station_table_core.sv
`default_nettype none

// Sorted station table: up to TABLE_DEPTH stations kept in rising frequency order,
// each with an eight-character name payload, held in one synchronous memory.
// in_ch carries one command per beat (seek up or down, store, remove, toggle,
// lookup, zap by index); out_ch returns exactly one result beat per command.
// Commands are served one at a time. A scan reads the table in order, each entry
// examined by a memory read and then a compare; store, remove and toggle then
// move entries one at a time (read, write back).
// The next command is taken once the result has moved into the output register,
// so a stalled receiver holds one finished result and lets one more command
// run; further commands wait while the output register stays full.
// Reset empties the table at once (count to zero); memory contents are not
// cleared, as only entries below the count are ever read.

module sorted_station_table_core #(
  parameter int TABLE_DEPTH = sst_pkg::DEF_TABLE_DEPTH
) (
  input  logic      clk,
  input  logic      rst_n,
  sst_in_if.sink    in_ch,
  sst_out_if.source out_ch
);

  import sst_pkg::*;

  localparam int IDX_W   = $clog2(TABLE_DEPTH);
  localparam int ENTRY_W = $bits(entry_t);

  logic             res_valid;
  logic             res_ready;
  res_t             res;
  logic             seq_in_ready;
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  entry_t           ram_wdata;
  logic             ram_re;
  logic [IDX_W-1:0] ram_raddr;
  entry_t           ram_rdata;
  logic             out_valid_r;
  res_t             out_res_r;

  sst_seq #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (seq_in_ready),
    .in_op    (in_ch.op),
    .in_freq  (in_ch.freq),
    .in_slot  (in_ch.slot),
    .in_label (in_ch.label),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res      (res),
    .ram_we   (ram_we),
    .ram_waddr(ram_waddr),
    .ram_wdata(ram_wdata),
    .ram_re   (ram_re),
    .ram_raddr(ram_raddr),
    .ram_rdata(ram_rdata)
  );

  sst_ram #(
    .DEPTH(TABLE_DEPTH),
    .WIDTH(ENTRY_W)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign in_ch.ready = seq_in_ready;

  // Output register: takes a result whenever it is empty or being drained.
  assign res_ready = !out_valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res_r <= res;
    end
  end

  // Result beat.
  assign out_ch.valid       = out_valid_r;
  assign out_ch.tune_valid  = out_res_r.tune_valid;
  assign out_ch.tune_freq   = out_res_r.tune_freq;
  assign out_ch.found       = out_res_r.found;
  assign out_ch.found_index = out_res_r.found_index;
  assign out_ch.label_out   = out_res_r.label_out;
  assign out_ch.entry_count = out_res_r.entry_count;
  assign out_ch.status      = out_res_r.status;

endmodule

`default_nettype wire
